// ----- rtl/sorted_min_priority_queue_assert.svh -----
// assertion macros for the sorted min priority queue
// used by the controller and datapath modules, no other dependencies
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smpq_pkg.sv -----
// shared types and constants of the sorted min priority queue
// no dependencies
package smpq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic signed [VALUE_W-1:0] EMPTY_HEAD = -32'sd1;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_HEAD,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REJECT_FULL,
    OP_REJECT_EMPTY,
    OP_PUSH_FIRST,
    OP_PUSH_START,
    OP_SHIFT,
    OP_PLACE_TAIL,
    OP_PLACE_HEAD,
    OP_POP,
    OP_LOAD_HEAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
    logic k_zero;
    logic greater;
  } dp_sts_t;

endpackage

// ----- rtl/smpq_if.sv -----
// valid/ready channel interfaces for the queue request and result
// depends on smpq_pkg
interface smpq_in_if import smpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface smpq_out_if import smpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic signed [VALUE_W-1:0] head_value;
  logic [FILL_W-1:0]         fill_count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output removed_value, output head_value,
                  output fill_count, output status, input ready);
  modport sink   (input valid, input removed_value, input head_value,
                  input fill_count, input status, output ready);
endinterface

// ----- rtl/sorted_min_priority_queue.sv -----
// sequence: a push scans from the tail, moving each larger entry up one slot,
// then writes its value; a push to an empty queue, a dropped push and a pop skip it
// throughput: one item at a time, the next accepted once the result is registered;
// push cost is set by the serial tail-to-head scan over the single-write entry ram
// reset: asynchronous active low, clears count, head pointer and control state;
// the entry ram is not cleared, no clearing pass
module sorted_min_priority_queue import smpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_in_if.sink     in_i,
  smpq_out_if.source  out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_value_i      (in_i.value),
    .removed_value_o (out_o.removed_value),
    .head_value_o    (out_o.head_value),
    .fill_count_o    (out_o.fill_count),
    .status_o        (out_o.status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

// ----- rtl/smpq_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module smpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/smpq_ctrl.sv -----
// control state machine of the sorted min priority queue
// depends on smpq_pkg and the assertion macro header
`include "sorted_min_priority_queue_assert.svh"

module smpq_ctrl import smpq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_action_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_PUSH) begin
            state_d = (sts_i.full || sts_i.empty) ? S_DONE : S_SCAN;
          end else begin
            state_d = (sts_i.empty || sts_i.last) ? S_DONE : S_HEAD;
          end
        end
      end
      S_SCAN: begin
        if (!sts_i.greater) begin
          state_d = S_DONE;
        end else if (sts_i.k_zero) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: state_d = S_DONE;
      S_HEAD:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_PUSH) begin
            if (sts_i.full) begin
              cmd_o.op = OP_REJECT_FULL;
            end else if (sts_i.empty) begin
              cmd_o.op = OP_PUSH_FIRST;
            end else begin
              cmd_o.op = OP_PUSH_START;
            end
          end else begin
            cmd_o.op = sts_i.empty ? OP_REJECT_EMPTY : OP_POP;
          end
        end
      end
      S_SCAN: begin
        cmd_o.op = sts_i.greater ? OP_SHIFT : OP_PLACE_TAIL;
      end
      S_PLACE: cmd_o.op = OP_PLACE_HEAD;
      S_HEAD:  cmd_o.op = OP_LOAD_HEAD;
      S_DONE:  cmd_o.load_out = out_free;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SMPQ_ASSERT_IMPL(a_scan_nonempty, clk_i, rst_ni, state_q == S_SCAN, !sts_i.empty, "scan on empty queue")
  `SMPQ_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni, (state_q == S_DONE) && out_free, (state_q == S_IDLE) && out_valid_q, "result not loaded on completion")

endmodule

// ----- rtl/smpq_dp.sv -----
// datapath: circular sorted entry store, head/count registers, result register
// depends on smpq_pkg, smpq_ram and the assertion macro header
`include "sorted_min_priority_queue_assert.svh"

module smpq_dp import smpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  input  logic signed [VALUE_W-1:0]  in_value_i,
  output logic signed [VALUE_W-1:0]  removed_value_o,
  output logic signed [VALUE_W-1:0]  head_value_o,
  output logic [FILL_W-1:0]          fill_count_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // logical position to ram address, base and offset both below capacity
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(CAPACITY)) begin
      sum = sum - (PTR_W + 1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0]          head_ptr_q, head_ptr_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [VALUE_W-1:0] head_q, head_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic [PTR_W-1:0]          k_q, k_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  status_e                   status_q, status_d;

  logic signed [VALUE_W-1:0] out_removed_q, out_removed_d;
  logic signed [VALUE_W-1:0] out_head_q, out_head_d;
  logic [FILL_W-1:0]         out_fill_q, out_fill_d;
  status_e                   out_status_q, out_status_d;

  logic                      wr_en, rd_en;
  logic [PTR_W-1:0]          wr_addr, rd_addr;
  logic [VALUE_W-1:0]        wr_data, rd_data;
  logic signed [VALUE_W-1:0] rdata;

  logic [PTR_W-1:0]          k_inc, k_dec, head_next;
  logic [CNT_W-1:0]          cnt_inc, cnt_dec;
  logic [CNT_W+FILL_W-1:0]   cnt_ext;

  smpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rdata     = $signed(rd_data);
  assign k_inc     = k_q + PTR_W'(1);
  assign k_dec     = k_q - PTR_W'(1);
  assign head_next = phys(head_ptr_q, PTR_W'(1));
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign cnt_ext   = (CNT_W + FILL_W)'(cnt_q);

  assign sts_o.empty   = (cnt_q == '0);
  assign sts_o.full    = (cnt_q == CNT_W'(CAPACITY));
  assign sts_o.last    = (cnt_q == CNT_W'(1));
  assign sts_o.k_zero  = (k_q == '0);
  assign sts_o.greater = (rdata > val_q);

  always_comb begin
    head_ptr_d = head_ptr_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    val_d      = val_q;
    k_d        = k_q;
    removed_d  = removed_q;
    status_d   = status_q;
    wr_en      = 1'b0;
    wr_addr    = phys(head_ptr_q, k_inc);
    wr_data    = val_q;
    rd_en      = 1'b0;
    rd_addr    = phys(head_ptr_q, k_dec);

    unique case (cmd_i.op)
      OP_NONE: ;
      OP_REJECT_FULL: begin
        removed_d = '0;
        status_d  = ST_PUSH_FULL;
      end
      OP_REJECT_EMPTY: begin
        removed_d = '0;
        status_d  = ST_POP_EMPTY;
      end
      OP_PUSH_FIRST: begin
        wr_en     = 1'b1;
        wr_addr   = head_ptr_q;
        wr_data   = in_value_i;
        head_d    = in_value_i;
        cnt_d     = cnt_inc;
        removed_d = '0;
        status_d  = ST_OK;
      end
      OP_PUSH_START: begin
        // start the scan at the tail entry
        val_d     = in_value_i;
        if (in_value_i < head_q) begin
          head_d = in_value_i;
        end
        k_d       = cnt_dec[PTR_W-1:0];
        rd_en     = 1'b1;
        rd_addr   = phys(head_ptr_q, cnt_dec[PTR_W-1:0]);
        cnt_d     = cnt_inc;
        removed_d = '0;
        status_d  = ST_OK;
      end
      OP_SHIFT: begin
        // move entry k up one slot and fetch entry k-1
        wr_en   = 1'b1;
        wr_data = rd_data;
        rd_en   = !sts_o.k_zero;
        k_d     = k_dec;
      end
      OP_PLACE_TAIL: begin
        wr_en = 1'b1;
      end
      OP_PLACE_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = head_ptr_q;
      end
      OP_POP: begin
        removed_d  = head_q;
        status_d   = ST_OK;
        head_ptr_d = head_next;
        cnt_d      = cnt_dec;
        rd_en      = !sts_o.last;
        rd_addr    = head_next;
      end
      OP_LOAD_HEAD: begin
        head_d = rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_removed_d = out_removed_q;
    out_head_d    = out_head_q;
    out_fill_d    = out_fill_q;
    out_status_d  = out_status_q;
    if (cmd_i.load_out) begin
      out_removed_d = removed_q;
      out_head_d    = sts_o.empty ? EMPTY_HEAD : head_q;
      out_fill_d    = cnt_ext[FILL_W-1:0];
      out_status_d  = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr_q <= '0;
      cnt_q      <= '0;
    end else begin
      head_ptr_q <= head_ptr_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q        <= head_d;
    val_q         <= val_d;
    k_q           <= k_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    out_removed_q <= out_removed_d;
    out_head_q    <= out_head_d;
    out_fill_q    <= out_fill_d;
    out_status_q  <= out_status_d;
  end

  assign removed_value_o = out_removed_q;
  assign head_value_o    = out_head_q;
  assign fill_count_o    = out_fill_q;
  assign status_o        = out_status_q;

  `SMPQ_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(CAPACITY), "fill count above capacity")
  `SMPQ_ASSERT_IMPL(a_ptr_bound, clk_i, rst_ni, 1'b1, {1'b0, head_ptr_q} < (PTR_W + 1)'(CAPACITY), "head pointer out of range")
  `SMPQ_ASSERT_NEXT(a_pop_count, clk_i, rst_ni, cmd_i.op == OP_POP, cnt_q == $past(cnt_q) - CNT_W'(1), "pop did not decrement count")

endmodule

// ----- sim/smpq_checker.sv -----
// checker for the sorted min priority queue: watches both channels, predicts
// each result from a sorted model of the stored values and compares field by field
// depends on smpq_pkg and the channel interfaces in smpq_if.sv
module smpq_checker import smpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_in_if          in_mon,
  smpq_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] head_value;
    logic [FILL_W-1:0]         fill_count;
    status_e                   status;
  } queue_result_t;

  logic signed [VALUE_W-1:0] sorted_values[$];
  queue_result_t             expected_results[$];
  queue_result_t             want;
  int unsigned               fail_count = 0;
  int unsigned               pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  // one step of the sorted queue, updates the stored values
  function automatic queue_result_t apply_request(action_e act,
                                                  logic signed [VALUE_W-1:0] val);
    queue_result_t res;
    int            pos;
    res.removed_value = '0;
    res.status        = ST_OK;
    if (act == ACT_PUSH) begin
      if (sorted_values.size() >= CAPACITY) begin
        res.status = ST_PUSH_FULL;
      end else begin
        // new value goes behind every stored value that is equal or smaller
        pos = sorted_values.size();
        for (int i = 0; i < sorted_values.size(); i++) begin
          if (sorted_values[i] > val) begin
            pos = i;
            break;
          end
        end
        sorted_values.insert(pos, val);
      end
    end else begin
      if (sorted_values.size() == 0) begin
        res.status = ST_POP_EMPTY;
      end else begin
        res.removed_value = sorted_values.pop_front();
      end
    end
    res.head_value = (sorted_values.size() == 0) ? EMPTY_HEAD : sorted_values[0];
    res.fill_count = FILL_W'(sorted_values.size());
    return res;
  endfunction

  task automatic report_field(string field, logic signed [VALUE_W-1:0] exp_val,
                              logic signed [VALUE_W-1:0] got_val);
    if (exp_val !== got_val) begin
      fail_count++;
      $display("%0t smpq_checker: %s mismatch, expected %0d, actual %0d",
               $time, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_values.delete();
      expected_results.delete();
      pending_count = 0;
    end else begin
      // result side first: a result never belongs to a request taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t smpq_checker: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                   $time, out_mon.removed_value, out_mon.head_value,
                   out_mon.fill_count, out_mon.status);
        end else begin
          want = expected_results.pop_front();
          report_field("removed_value", want.removed_value, out_mon.removed_value);
          report_field("head_value", want.head_value, out_mon.head_value);
          report_field("fill_count", VALUE_W'(want.fill_count),
                       VALUE_W'({1'b0, out_mon.fill_count}));
          report_field("status", VALUE_W'(want.status), VALUE_W'({1'b0, out_mon.status}));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_request(action_e'(in_mon.action), in_mon.value));
      pending_count = expected_results.size();
    end
  end

endmodule

// ----- sim/tb_sorted_min_priority_queue.sv -----
// testbench top for the sorted min priority queue: clock, reset, request and
// result traffic with random gaps, watchdog and verdict
// depends on smpq_pkg, smpq_if.sv, the block and smpq_checker
module tb_sorted_min_priority_queue import smpq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned RESET_CYC   = 9;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 142;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned TAIL_CYC    = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          no_idle;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned push_pct[PHASES] = '{90, 50, 15, 70, 35, 95, 10, 55};

  smpq_in_if  in_if ();
  smpq_out_if out_if ();

  sorted_min_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  smpq_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // mix of duplicates, extremes and full-range values
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)
      return VALUE_W'($signed($urandom_range(0, 8)) - 4);
    if (sel < 42) begin
      case ($urandom_range(0, 5))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return 32'sh7fff_fffe;
        3:       return 32'sh8000_0001;
        4:       return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_request(action_e act, logic signed [VALUE_W-1:0] val);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.value  <= val;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // hold requests back until every outstanding result has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.action  <= ACT_PUSH;
    in_if.value   <= '0;
    out_if.ready  <= 1'b0;
    no_idle       = 1'b0;
    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pop on empty, extremes, equal values, drain past empty
    send_request(ACT_POP, '0);
    send_request(ACT_PUSH, 32'sh7fff_ffff);
    send_request(ACT_PUSH, 32'sh8000_0000);
    send_request(ACT_PUSH, '0);
    send_request(ACT_PUSH, -32'sd1);
    send_request(ACT_PUSH, -32'sd1);
    send_request(ACT_PUSH, 32'sd1);
    repeat (7) send_request(ACT_POP, $urandom());
    drain_results();

    // random phases with different push bias, odd phases without gaps
    for (int p = 0; p < PHASES; p++) begin
      no_idle = p[0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < push_pct[p])
          send_request(ACT_PUSH, pick_value());
        else
          send_request(ACT_POP, $urandom());
      end
      drain_results();
    end

    no_idle = 1'b0;
    repeat (TAIL_CYC) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_sorted_min_priority_queue: done, clean");
    else
      $display("tb_sorted_min_priority_queue: done, errors");
    $finish;
  end

  // result side, one wait draw per transaction
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // ends a hung run: too many cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_sorted_min_priority_queue: done, errors");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

// ----- sorted_min_priority_queue.f -----
+incdir+rtl
rtl/smpq_pkg.sv
rtl/smpq_if.sv
rtl/smpq_ram.sv
rtl/smpq_ctrl.sv
rtl/smpq_dp.sv
rtl/sorted_min_priority_queue.sv
sim/smpq_checker.sv
sim/tb_sorted_min_priority_queue.sv
